// ----- hw/rtl/sph_pkg.sv -----
// shared types, register map and helpers for the smoothed presence detector
package sph_pkg;

   // register map: register i at byte address 4*i
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned LevelWidth   = 16;
   localparam int unsigned CountWidth   = 17;
   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned RspDataWidth = 24;

   typedef enum logic [1:0] {
      REG_WEIGHT    = 2'd0,
      REG_THRESHOLD = 2'd1,
      REG_ENTER     = 2'd2,
      REG_LEAVE     = 2'd3
   } csr_index_type;

   // configuration values as seen by the datapath
   typedef struct packed {
      logic [15:0]        weight;
      logic signed [15:0] threshold;
      logic [15:0]        enter_frames;
      logic [15:0]        leave_frames;
   } cfg_type;

   // one result item
   typedef struct packed {
      logic               is_active;
      logic signed [15:0] level;
   } result_type;

   // clamp a wide signed value into the Q8.8 level range
   function automatic logic signed [15:0] sat_level(input logic signed [19:0] v);
      logic signed [15:0] r;
      if (v > 20'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -20'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/sph_csr.sv -----
// configuration register file behind the apb-style port
module sph_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sph_pkg::CsrAddrWidth-1:0]      csr_paddr,
   input  logic [sph_pkg::CsrDataWidth-1:0]      csr_pwdata,
   output logic [sph_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic                                  csr_pready,
   output sph_pkg::cfg_type                      cfg
);

   sph_pkg::cfg_type       cfg_ff, cfg_in;
   sph_pkg::csr_index_type index;
   logic                   write_en;

   assign index    = sph_pkg::csr_index_type'(csr_paddr[3:2]);
   assign write_en = csr_psel && csr_penable && csr_pwrite;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (index)
            sph_pkg::REG_WEIGHT:    cfg_in.weight       = csr_pwdata[15:0];
            sph_pkg::REG_THRESHOLD: cfg_in.threshold    = csr_pwdata[15:0];
            sph_pkg::REG_ENTER:     cfg_in.enter_frames = csr_pwdata[15:0];
            sph_pkg::REG_LEAVE:     cfg_in.leave_frames = csr_pwdata[15:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         sph_pkg::REG_WEIGHT:    csr_prdata = {16'd0, cfg_ff.weight};
         sph_pkg::REG_THRESHOLD: csr_prdata = {16'd0, cfg_ff.threshold};
         sph_pkg::REG_ENTER:     csr_prdata = {16'd0, cfg_ff.enter_frames};
         sph_pkg::REG_LEAVE:     csr_prdata = {16'd0, cfg_ff.leave_frames};
         default:                csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

// ----- hw/rtl/sph_core.sv -----
// level smoothing, threshold compare and enter/leave debounce state
module sph_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic signed [15:0]      main_feature,
   input  logic signed [15:0]      side_feature,
   input  sph_pkg::cfg_type        cfg,
   output sph_pkg::result_type     result
);

   logic signed [15:0] level_ff, level_in;
   logic               first_ff, first_in;
   logic               active_ff, active_in;
   logic [16:0]        count_ff, count_in;

   logic signed [16:0] diff;
   logic [16:0]        inv_weight;
   logic signed [16:0] weight_s;
   logic signed [17:0] inv_weight_s;
   logic signed [32:0] old_term;
   logic signed [34:0] new_term;
   logic signed [35:0] acc;
   logic signed [19:0] scaled;
   logic               cand;
   logic [16:0]        count_inc;
   logic [15:0]        limit;

   // exact 17-bit difference of the two features
   assign diff = {main_feature[15], main_feature} - {side_feature[15], side_feature};

   // weighted sum of old level and new difference, rounded half up
   assign inv_weight   = 17'h10000 - {1'b0, cfg.weight};
   assign weight_s     = {1'b0, cfg.weight};
   assign inv_weight_s = {1'b0, inv_weight};
   assign old_term     = level_ff * weight_s;
   assign new_term     = diff * inv_weight_s;
   assign acc          = 36'(old_term) + 36'(new_term) + 36'sd32768;
   assign scaled       = acc[35:16];

   // level update, first frame loads the difference directly
   always_comb begin
      if (first_ff) begin
         level_in = sph_pkg::sat_level(20'(diff));
      end else begin
         level_in = sph_pkg::sat_level(scaled);
      end
      first_in = 1'b0;
   end

   // debounce counter and active flag
   assign cand      = level_in > cfg.threshold;
   assign count_inc = count_ff + 17'd1;
   assign limit     = active_ff ? cfg.leave_frames : cfg.enter_frames;

   always_comb begin
      active_in = active_ff;
      count_in  = '0;
      if (cand != active_ff) begin
         if (count_inc > {1'b0, limit}) begin
            active_in = cand;
            count_in  = '0;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         first_ff  <= 1'b1;
         active_ff <= 1'b0;
         count_ff  <= '0;
      end else if (advance) begin
         level_ff  <= level_in;
         first_ff  <= first_in;
         active_ff <= active_in;
         count_ff  <= count_in;
      end
   end

   assign result.is_active = active_in;
   assign result.level     = level_in;

endmodule

// ----- hw/rtl/smoothed_presence_hysteresis.sv -----
// smoothed presence detector with enter/leave hysteresis, top level
// a request passes the input reg, then the result reg; the level feedback closes
// in the single compute stage; throughput: one request per cycle while results are taken
// an empty input register takes a new request while a result waits in the result register
// reset: synchronous, active high; clears valids, configuration and detector state
module smoothed_presence_hysteresis (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // [15:0] main_feature, [31:16] side_feature
   input  logic [sph_pkg::ReqDataWidth-1:0]      req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [0] is_active, [16:1] smoothed_level, [23:17] zero
   output logic [sph_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [sph_pkg::CsrAddrWidth-1:0]      csr_paddr,
   input  logic [sph_pkg::CsrDataWidth-1:0]      csr_pwdata,
   output logic [sph_pkg::CsrDataWidth-1:0]      csr_prdata,
   output logic                                  csr_pready
);

   logic                s1_valid_ff, s1_valid_in;
   logic signed [15:0]  s1_main_ff, s1_side_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   sph_pkg::result_type rsp_data_ff;
   sph_pkg::result_type result;
   sph_pkg::cfg_type    cfg;
   logic                advance;
   logic                req_accept;

   sph_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake control between input register and result register
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !s1_valid_ff || advance;
   assign req_accept   = req_tvalid && req_tready;
   assign s1_valid_in  = req_accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request payload register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_main_ff <= req_tdata[15:0];
         s1_side_ff <= req_tdata[31:16];
      end
   end

   sph_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .main_feature (s1_main_ff),
      .side_feature (s1_side_ff),
      .cfg          (cfg),
      .result       (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff.level, rsp_data_ff.is_active};

`ifndef SYNTH
   // an empty input stage always takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("input stage empty but request not taken");

   // a pending request moves on whenever the result register is free
   a_advance_when_free: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_valid_ff) |-> advance)
      else $error("pending request stuck with free result register");

   // a full pipe with a stalled result blocks new requests
   a_block_when_full: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request taken while pipe is full and stalled");

   // a result register that was loaded is valid in the next cycle
   a_result_after_advance: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request produced no result");
`endif

endmodule

// ----- dv/smoothed_presence_hysteresis_test.sv -----
// self-checking testbench for the smoothed presence detector with enter/leave hysteresis
module smoothed_presence_hysteresis_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int StallLimit  = 5000;
   localparam int HoldCycles  = 400;
   localparam int PhaseFrames = 140;
   localparam int RandPhases  = 8;
   localparam int ReportLimit = 10;

   // one request as the sender sees it, with an optional hand-typed result
   typedef struct packed {
      logic signed [15:0]  main_f;
      logic signed [15:0]  side_f;
      logic                known;
      sph_pkg::result_type want;
   } frame_req_type;

   typedef enum logic {
      ROW_FRAME,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      sph_pkg::csr_index_type sel;
      logic [15:0]            value;
      frame_req_type          frame;
   } script_row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [sph_pkg::ReqDataWidth-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [sph_pkg::RspDataWidth-1:0] rsp_tdata;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [sph_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [sph_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [sph_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                             csr_pready;

   smoothed_presence_hysteresis dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // detector state and settings as the testbench tracks them
   logic signed [15:0] tracked_level = '0;
   logic               level_primed = 1'b0;
   logic               tracked_active = 1'b0;
   logic [16:0]        debounce_run = '0;
   logic [15:0]        weight_cfg = '0;
   logic signed [15:0] threshold_cfg = '0;
   logic [15:0]        enter_cfg = '0;
   logic [15:0]        leave_cfg = '0;

   frame_req_type       frames_to_send[$];
   sph_pkg::result_type presence_expected[$];
   int                  failures = 0;

   // sender, receiver and watchdog bookkeeping
   frame_req_type       cur_frame;
   int                  burst_left = 0;
   int                  gap_left = 0;
   int                  seg_left = 0;
   int                  seg_mode = 0;
   int                  seg_tick = 0;
   int                  hold_left = 0;
   int                  hold_request = 0;
   int                  hold_seen = 0;
   int                  idle_cycles = 0;
   sph_pkg::result_type got_result;
   sph_pkg::result_type want_result;

   function automatic logic signed [15:0] clip_q88(longint v);
      if (v > 32767) begin
         return 16'sh7fff;
      end
      if (v < -32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   // advance the tracked detector by one frame and return its result
   function automatic sph_pkg::result_type next_presence(logic signed [15:0] main_f,
                                                         logic signed [15:0] side_f);
      logic signed [16:0]  diff;
      longint              acc;
      logic                cand;
      logic [15:0]         bound;
      sph_pkg::result_type r;
      diff = {main_f[15], main_f} - {side_f[15], side_f};
      if (!level_primed) begin
         tracked_level = clip_q88(longint'(diff));
         level_primed = 1'b1;
      end else begin
         acc = longint'(tracked_level) * longint'(weight_cfg)
             + longint'(diff) * (longint'(65536) - longint'(weight_cfg)) + 32768;
         tracked_level = clip_q88(acc >>> 16);
      end
      cand = tracked_level > threshold_cfg;
      // debounce: count disagreeing frames, clear on agreement
      if (cand != tracked_active) begin
         debounce_run = debounce_run + 17'd1;
         bound = tracked_active ? leave_cfg : enter_cfg;
         if (debounce_run > {1'b0, bound}) begin
            tracked_active = cand;
            debounce_run = '0;
         end
      end else begin
         debounce_run = '0;
      end
      r.is_active = tracked_active;
      r.level = tracked_level;
      return r;
   endfunction

   function automatic void report_failure(string msg);
      failures++;
      if (failures <= ReportLimit) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   function automatic frame_req_type plain_frame(int m, int s);
      frame_req_type f;
      f.main_f = m[15:0];
      f.side_f = s[15:0];
      f.known = 1'b0;
      f.want = '0;
      return f;
   endfunction

   function automatic script_row_type frame_row(int m, int s);
      script_row_type r;
      r.kind = ROW_FRAME;
      r.sel = sph_pkg::REG_WEIGHT;
      r.value = '0;
      r.frame = plain_frame(m, s);
      return r;
   endfunction

   function automatic script_row_type known_row(int m, int s, logic act, int lvl);
      script_row_type r;
      r = frame_row(m, s);
      r.frame.known = 1'b1;
      r.frame.want.is_active = act;
      r.frame.want.level = lvl[15:0];
      return r;
   endfunction

   function automatic script_row_type csr_row(sph_pkg::csr_index_type sel,
                                              logic [15:0] value);
      script_row_type r;
      r.kind = ROW_CSR;
      r.sel = sel;
      r.value = value;
      r.frame = '0;
      return r;
   endfunction

   function automatic logic [15:0] pick_count();
      case ($urandom_range(0, 7))
         6: return 16'hffff;
         7: return 16'($urandom);
         default: return 16'($urandom_range(0, 6));
      endcase
   endfunction

   // sender: bursts of requests with random gaps, prediction at acceptance
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         want_result = next_presence(cur_frame.main_f, cur_frame.side_f);
         presence_expected.push_back(cur_frame.known ? cur_frame.want : want_result);
      end
      if (!req_tvalid || req_tready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (frames_to_send.size() != 0) begin
            cur_frame = frames_to_send.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {cur_frame.side_f, cur_frame.main_f};
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: checks each result, stalls on segments of its own pattern
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         got_result.is_active = rsp_tdata[0];
         got_result.level = rsp_tdata[16:1];
         if (presence_expected.size() == 0) begin
            report_failure($sformatf("result without request: active %0b level %0d",
                                     got_result.is_active, got_result.level));
         end else begin
            want_result = presence_expected.pop_front();
            if (got_result.is_active !== want_result.is_active) begin
               report_failure($sformatf("is_active: expected %0b, got %0b",
                                        want_result.is_active, got_result.is_active));
            end
            if (got_result.level !== want_result.level) begin
               report_failure($sformatf("smoothed_level: expected %0d, got %0d",
                                        want_result.level, got_result.level));
            end
         end
      end
      if (hold_request != hold_seen) begin
         hold_seen = hold_request;
         hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(16, 160);
            seg_mode = $urandom_range(0, 3);
         end
         seg_left--;
         seg_tick++;
         case (seg_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 2) == 0);
            default: rsp_tready <= (seg_tick % 3 != 0);
         endcase
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // block is idle once nothing is queued, offered or outstanding
   task automatic wait_until_settled();
      while (frames_to_send.size() != 0 || req_tvalid || presence_expected.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // register write followed by a read back of the same register
   task automatic write_csr(sph_pkg::csr_index_type sel, logic [15:0] value);
      logic [sph_pkg::CsrDataWidth-1:0] readback;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {sel, 2'b00};
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (sel)
         sph_pkg::REG_WEIGHT:    weight_cfg = value;
         sph_pkg::REG_THRESHOLD: threshold_cfg = value;
         sph_pkg::REG_ENTER:     enter_cfg = value;
         default:                leave_cfg = value;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (readback[15:0] !== value) begin
         report_failure($sformatf("register %s: expected %h, read %h",
                                  sel.name(), value, readback[15:0]));
      end
   endtask

   // frames in runs around the threshold, some noise; or all above the level floor
   task automatic queue_frames(int count, bit above_floor);
      int run_left;
      int target;
      int m;
      int s;
      int t;
      run_left = 0;
      target = 0;
      repeat (count) begin
         m = int'($urandom_range(0, 65535)) - 32768;
         s = int'($urandom_range(0, 65535)) - 32768;
         if (above_floor) begin
            if (m - s <= -32768) begin
               t = m;
               m = s;
               s = t;
            end
         end else begin
            if (run_left == 0) begin
               run_left = $urandom_range(1, 24);
               if ($urandom_range(0, 4) != 0) begin
                  target = int'(threshold_cfg) + int'($urandom_range(0, 1536)) - 768;
               end else begin
                  target = int'($urandom_range(0, 131070)) - 65535;
               end
            end
            run_left--;
            if ($urandom_range(0, 9) != 0) begin
               m = s + target + int'($urandom_range(0, 64)) - 32;
               if (m > 32767) m = 32767;
               if (m < -32768) m = -32768;
            end
         end
         frames_to_send.push_back(plain_frame(m, s));
      end
   endtask

   script_row_type script[$];

   initial begin
      // reset defaults first, then extreme weight and threshold values and debounce limits
      script = '{
         known_row(32767, -32768, 1'b1, 32767),
         known_row(-32768, 32767, 1'b0, -32768),
         known_row(0, 0, 1'b0, 0),
         known_row(1, 0, 1'b1, 1),
         csr_row(sph_pkg::REG_WEIGHT, 16'hffff),
         csr_row(sph_pkg::REG_THRESHOLD, 16'h7fff),
         frame_row(-32768, 32767),
         frame_row(32767, -32768),
         frame_row(16'h1234, 16'h0f00),
         csr_row(sph_pkg::REG_WEIGHT, 16'h8000),
         csr_row(sph_pkg::REG_THRESHOLD, 16'h8000),
         csr_row(sph_pkg::REG_ENTER, 16'h0003),
         csr_row(sph_pkg::REG_LEAVE, 16'h0002),
         frame_row(32767, 32767),
         frame_row(-32768, -32768),
         frame_row(256, -256),
         frame_row(32767, 0),
         frame_row(0, 32767),
         frame_row(-32768, 32767),
         frame_row(-32768, 32767),
         frame_row(-32768, 32767),
         csr_row(sph_pkg::REG_WEIGHT, 16'h0000),
         csr_row(sph_pkg::REG_THRESHOLD, 16'h0100),
         csr_row(sph_pkg::REG_ENTER, 16'h0000),
         csr_row(sph_pkg::REG_LEAVE, 16'hffff),
         frame_row(512, 0),
         frame_row(-256, 0),
         frame_row(255, 0),
         frame_row(257, 0),
         frame_row(-21846, 21845)
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (script[i]) begin
         if (script[i].kind == ROW_CSR) begin
            wait_until_settled();
            write_csr(script[i].sel, script[i].value);
         end else begin
            frames_to_send.push_back(script[i].frame);
         end
      end
      wait_until_settled();

      // long enter streak on the debounce counter: force inactive, then one run
      write_csr(sph_pkg::REG_WEIGHT, 16'h0000);
      write_csr(sph_pkg::REG_THRESHOLD, 16'h7fff);
      write_csr(sph_pkg::REG_LEAVE, 16'h0000);
      frames_to_send.push_back(plain_frame(0, 0));
      wait_until_settled();
      write_csr(sph_pkg::REG_THRESHOLD, 16'h8000);
      write_csr(sph_pkg::REG_ENTER, 16'd50);
      queue_frames(60, 1'b1);
      wait_until_settled();

      // random settings and frames, each phase starts from an idle block
      for (int phase = 0; phase < RandPhases; phase++) begin
         case ($urandom_range(0, 3))
            0: write_csr(sph_pkg::REG_WEIGHT, 16'h0000);
            1: write_csr(sph_pkg::REG_WEIGHT, 16'hffff);
            2: write_csr(sph_pkg::REG_WEIGHT, 16'($urandom));
            default: write_csr(sph_pkg::REG_WEIGHT,
                               16'hf000 | 16'($urandom_range(0, 4095)));
         endcase
         case ($urandom_range(0, 5))
            0: write_csr(sph_pkg::REG_THRESHOLD, 16'h8000);
            1: write_csr(sph_pkg::REG_THRESHOLD, 16'h7fff);
            2, 3: write_csr(sph_pkg::REG_THRESHOLD, 16'($urandom_range(0, 4000) - 2000));
            default: write_csr(sph_pkg::REG_THRESHOLD, 16'($urandom));
         endcase
         write_csr(sph_pkg::REG_ENTER, pick_count());
         write_csr(sph_pkg::REG_LEAVE, pick_count());
         queue_frames(PhaseFrames, 1'b0);
         // long receiver hold-off while the sender keeps offering
         if (phase == 2) begin
            hold_request <= hold_request + 1;
         end
         wait_until_settled();
      end

      repeat (8) @(posedge clock);
      if (failures == 0 && presence_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/sph_pkg.sv
hw/rtl/sph_csr.sv
hw/rtl/sph_core.sv
hw/rtl/smoothed_presence_hysteresis.sv
dv/smoothed_presence_hysteresis_test.sv
